// File: src/gmt_pkg.sv
// ----------------------------------------------------------------------------
// gmt_pkg
// Shared types and constants of the gossip membership table.
// ----------------------------------------------------------------------------
`default_nettype none
package gmt_pkg;

	localparam int unsigned ADDR_W       = 48;
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned TIMEOUT_W    = 16;
	localparam int unsigned PICK_W       = 16;
	localparam int unsigned COUNT_W      = 6;
	localparam int unsigned KIND_W       = 3;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned TABLE_DEPTH  = 32;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_GOSSIP     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_JOIN_REQ   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_JOIN_REPLY = 3'd2;
	localparam logic [KIND_W-1:0] KIND_TICK       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_START      = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TIMEOUT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEANUP_TIMEOUT = 2'd2;

	localparam logic [TIMEOUT_W-1:0] FAIL_TIMEOUT_RST    = 16'd5;
	localparam logic [TIMEOUT_W-1:0] CLEANUP_TIMEOUT_RST = 16'd20;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] node_address;
		logic [WORD_W-1:0] beat_count;
		logic              failed_flag;
		logic [WORD_W-1:0] now;
		logic [PICK_W-1:0] random_pick;
	} in_t;

	typedef struct packed {
		logic               is_send;
		logic [ADDR_W-1:0]  target_address;
		logic [ADDR_W-1:0]  entry_address;
		logic [WORD_W-1:0]  entry_beats;
		logic               entry_failed;
		logic [WORD_W-1:0]  entry_stamp;
		logic               last;
		logic [COUNT_W-1:0] member_count;
		logic               joined;
		logic               accepted;
	} out_t;

	// one table entry as stored in the memory
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] beats;
		logic [WORD_W-1:0] stamp;
		logic              failed;
	} ent_t;

	// result of an item that sends nothing
	function automatic out_t quiet_result(logic [COUNT_W-1:0] count, logic joined,
		logic acc);
		out_t r;
		r              = '0;
		r.last         = 1'b1;
		r.member_count = count;
		r.joined       = joined;
		r.accepted     = acc;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/gmt_ram.sv
// ----------------------------------------------------------------------------
// gmt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module gmt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/gossip_membership_table.sv
// ----------------------------------------------------------------------------
// gossip_membership_table
// Bounded member table with heartbeat failure detection, held in one RAM.
// ----------------------------------------------------------------------------
// channel | direction | handshake                 | payload
// item    | in        | start && !busy            | item (in_t)
// result  | out       | result_valid, one cycle   | result (out_t)
// config  | in        | cfg_valid && cfg_ready    | cfg_index, cfg_data
//
// Immediate kinds (join reply, start, rejected items) answer straight from
// idle with a registered result. A merge reads and compares each entry
// scanned; a join request reads and sends each entry in turn. A tick runs
// the own heartbeat, cleanup and failure passes, a bit-serial pick modulo,
// the target candidate scan and the send: every step waits on the single
// RAM read port. Reset clears control state; the table needs no clearing
// pass. Results cannot be stalled; config is always ready.
`default_nettype none
module gossip_membership_table #(
	parameter int unsigned TABLE_DEPTH = gmt_pkg::TABLE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire gmt_pkg::in_t                     item,
	output logic                                  result_valid,
	output gmt_pkg::out_t                         result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [gmt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gmt_pkg::ADDR_W-1:0]       cfg_data
);

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned EW = $bits(gmt_pkg::ent_t);
	localparam logic [SW-1:0] DEPTH_C = SW'(TABLE_DEPTH);
	localparam logic [SW-1:0] ONE_C   = SW'(1);
	localparam int unsigned PCW = $clog2(gmt_pkg::PICK_W);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_MG_RD  = 15'b000000000000010,
		ST_MG_EX  = 15'b000000000000100,
		ST_OWN_RD = 15'b000000000001000,
		ST_OWN_EX = 15'b000000000010000,
		ST_CL_RD  = 15'b000000000100000,
		ST_CL_EX  = 15'b000000001000000,
		ST_CL_MV  = 15'b000000010000000,
		ST_FL_RD  = 15'b000000100000000,
		ST_FL_EX  = 15'b000001000000000,
		ST_MOD    = 15'b000010000000000,
		ST_TG_RD  = 15'b000100000000000,
		ST_TG_EX  = 15'b001000000000000,
		ST_TX_RD  = 15'b010000000000000,
		ST_TX_EX  = 15'b100000000000000
	} state_t;

	state_t                          state_q;
	gmt_pkg::in_t                    item_q;
	logic [SW-1:0]                   size_q;
	logic                            joined_q;
	logic [SW-1:0]                   i_q;
	logic [SW-1:0]                   n_q;
	logic [SW-1:0]                   idx_q;
	logic [SW-1:0]                   nfail_q;
	logic [SW-1:0]                   rem_q;
	logic [PCW-1:0]                  bit_q;
	logic [gmt_pkg::ADDR_W-1:0]      target_q;
	logic [gmt_pkg::ADDR_W-1:0]      own_q;
	logic [gmt_pkg::TIMEOUT_W-1:0]   fail_to_q;
	logic [gmt_pkg::TIMEOUT_W-1:0]   clean_to_q;
	logic                            res_valid_q;
	gmt_pkg::out_t                   res_q;

	logic                            ram_we;
	logic [IW-1:0]                   ram_waddr;
	gmt_pkg::ent_t                   ram_wdata;
	logic                            ram_re;
	logic [IW-1:0]                   ram_raddr;
	logic [EW-1:0]                   ram_rbits;
	gmt_pkg::ent_t                   rd;

	logic                            accept;
	logic [gmt_pkg::WORD_W-1:0]      age;
	logic                            age_clean;
	logic                            age_fail;
	logic [SW:0]                     rem_try;
	logic                            room;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign rd           = gmt_pkg::ent_t'(ram_rbits);
	assign room         = (size_q < DEPTH_C);

	// age of the entry just read
	assign age       = item_q.now - rd.stamp;
	assign age_clean = (age >= {16'd0, clean_to_q});
	assign age_fail  = (age >= {16'd0, fail_to_q});

	// one restoring step of pick modulo size
	always_comb begin
		rem_try = {rem_q, item_q.random_pick[gmt_pkg::PICK_W - 1 - 32'(bit_q)]};
		if (rem_try >= {1'b0, size_q}) begin
			rem_try = rem_try - {1'b0, size_q};
		end
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = size_q[IW-1:0];
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = i_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				ram_wdata.addr  = item.node_address;
				ram_wdata.beats = 32'd1;
				ram_wdata.stamp = item.now;
				if (accept && room) begin
					if (item.kind == gmt_pkg::KIND_JOIN_REPLY && item.node_address != '0)
					begin
						ram_we           = 1'b1;
						ram_wdata.beats  = item.beat_count;
						ram_wdata.failed = item.failed_flag;
					end else if (item.kind == gmt_pkg::KIND_START && !joined_q) begin
						ram_we         = 1'b1;
						ram_wdata.addr = own_q;
					end else if (item.kind == gmt_pkg::KIND_JOIN_REQ && joined_q &&
						item.node_address != '0) begin
						ram_we = 1'b1;
					end
				end
			end
			ST_MG_RD: begin
				ram_wdata.addr  = item_q.node_address;
				ram_wdata.beats = item_q.beat_count;
				ram_wdata.stamp = item_q.now;
				if (i_q >= size_q) begin
					ram_we = room;
				end else begin
					ram_re = 1'b1;
				end
			end
			ST_MG_EX: begin
				ram_waddr       = i_q[IW-1:0];
				ram_wdata.addr  = rd.addr;
				ram_wdata.beats = item_q.beat_count;
				ram_wdata.stamp = item_q.now;
				ram_we = (rd.addr == item_q.node_address) && (rd.beats < item_q.beat_count);
			end
			ST_OWN_RD, ST_CL_RD, ST_FL_RD, ST_TX_RD: begin
				ram_re = (i_q < size_q);
			end
			ST_OWN_EX: begin
				ram_waddr       = i_q[IW-1:0];
				ram_wdata       = rd;
				ram_wdata.beats = rd.beats + 32'd1;
				ram_wdata.stamp = item_q.now;
				ram_we          = (rd.addr == own_q);
			end
			ST_CL_EX: begin
				ram_raddr = IW'(size_q - ONE_C);
				ram_re    = rd.failed && age_clean;
			end
			ST_CL_MV: begin
				ram_waddr = i_q[IW-1:0];
				ram_wdata = rd;
				ram_we    = 1'b1;
			end
			ST_FL_EX: begin
				ram_waddr        = i_q[IW-1:0];
				ram_wdata        = rd;
				ram_wdata.failed = 1'b1;
				ram_we           = age_fail && !rd.failed;
			end
			ST_TG_RD: begin
				ram_raddr = idx_q[IW-1:0];
				ram_re    = (n_q < size_q);
			end
			default: begin
			end
		endcase
	end

	gmt_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (EW'(ram_wdata)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q      <= '0;
			fail_to_q  <= gmt_pkg::FAIL_TIMEOUT_RST;
			clean_to_q <= gmt_pkg::CLEANUP_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gmt_pkg::CFG_OWN_ADDRESS:     own_q      <= cfg_data;
				gmt_pkg::CFG_FAIL_TIMEOUT:    fail_to_q  <= cfg_data[gmt_pkg::TIMEOUT_W-1:0];
				gmt_pkg::CFG_CLEANUP_TIMEOUT: clean_to_q <= cfg_data[gmt_pkg::TIMEOUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= '0;
			joined_q    <= 1'b0;
			i_q         <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			nfail_q     <= '0;
			rem_q       <= '0;
			bit_q       <= '0;
			target_q    <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					i_q <= '0;
					if (accept) begin
						if (item.kind == gmt_pkg::KIND_JOIN_REPLY) begin
							joined_q    <= 1'b1;
							res_valid_q <= 1'b1;
							if (item.node_address == '0) begin
								res_q <= gmt_pkg::quiet_result(
									gmt_pkg::COUNT_W'(size_q), 1'b1, 1'b1);
							end else begin
								if (room) size_q <= size_q + ONE_C;
								res_q <= gmt_pkg::quiet_result(
									gmt_pkg::COUNT_W'(room ? size_q + ONE_C : size_q),
									1'b1, room);
							end
						end else if (item.kind == gmt_pkg::KIND_START) begin
							res_valid_q <= 1'b1;
							if (!joined_q && room) begin
								size_q   <= size_q + ONE_C;
								joined_q <= 1'b1;
								res_q    <= gmt_pkg::quiet_result(
									gmt_pkg::COUNT_W'(size_q + ONE_C), 1'b1, 1'b1);
							end else begin
								res_q <= gmt_pkg::quiet_result(
									gmt_pkg::COUNT_W'(size_q), joined_q, 1'b0);
							end
						end else if (joined_q && item.kind == gmt_pkg::KIND_GOSSIP &&
							item.node_address != '0 && item.node_address != own_q &&
							!item.failed_flag) begin
							state_q <= ST_MG_RD;
						end else if (joined_q && item.kind == gmt_pkg::KIND_JOIN_REQ &&
							item.node_address != '0 && room) begin
							size_q   <= size_q + ONE_C;
							target_q <= item.node_address;
							state_q  <= ST_TX_RD;
						end else if (joined_q && item.kind == gmt_pkg::KIND_TICK) begin
							state_q <= ST_OWN_RD;
						end else begin
							res_valid_q <= 1'b1;
							res_q <= gmt_pkg::quiet_result(
								gmt_pkg::COUNT_W'(size_q), joined_q, 1'b0);
						end
					end
				end
				// merge: find the address and refresh it on a higher beat count, else append if there is room
				ST_MG_RD: begin
					if (i_q >= size_q) begin
						if (room) size_q <= size_q + ONE_C;
						res_valid_q <= 1'b1;
						res_q <= gmt_pkg::quiet_result(
							gmt_pkg::COUNT_W'(room ? size_q + ONE_C : size_q), 1'b1, room);
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_MG_EX;
					end
				end
				ST_MG_EX: begin
					if (rd.addr == item_q.node_address) begin
						res_valid_q <= 1'b1;
						res_q <= gmt_pkg::quiet_result(
							gmt_pkg::COUNT_W'(size_q), 1'b1, 1'b1);
						state_q <= ST_IDLE;
					end else begin
						i_q     <= i_q + ONE_C;
						state_q <= ST_MG_RD;
					end
				end
				// tick: own heartbeat
				ST_OWN_RD: begin
					if (i_q >= size_q) begin
						i_q     <= '0;
						state_q <= ST_CL_RD;
					end else begin
						state_q <= ST_OWN_EX;
					end
				end
				ST_OWN_EX: begin
					if (rd.addr == own_q) begin
						i_q     <= '0;
						state_q <= ST_CL_RD;
					end else begin
						i_q     <= i_q + ONE_C;
						state_q <= ST_OWN_RD;
					end
				end
				// tick: remove expired failed entries by swap with last
				ST_CL_RD: begin
					if (i_q >= size_q) begin
						i_q     <= '0;
						nfail_q <= '0;
						state_q <= ST_FL_RD;
					end else begin
						state_q <= ST_CL_EX;
					end
				end
				ST_CL_EX: begin
					if (rd.failed && age_clean) begin
						state_q <= ST_CL_MV;
					end else begin
						i_q     <= i_q + ONE_C;
						state_q <= ST_CL_RD;
					end
				end
				ST_CL_MV: begin
					size_q  <= size_q - ONE_C;
					state_q <= ST_CL_RD;
				end
				// tick: mark stale entries and count failures
				ST_FL_RD: begin
					if (i_q >= size_q) begin
						if (size_q > ONE_C && nfail_q < size_q - ONE_C) begin
							rem_q   <= '0;
							bit_q   <= '0;
							state_q <= ST_MOD;
						end else begin
							res_valid_q <= 1'b1;
							res_q <= gmt_pkg::quiet_result(
								gmt_pkg::COUNT_W'(size_q), 1'b1, 1'b1);
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_FL_EX;
					end
				end
				ST_FL_EX: begin
					if (rd.failed || age_fail) nfail_q <= nfail_q + ONE_C;
					i_q     <= i_q + ONE_C;
					state_q <= ST_FL_RD;
				end
				// tick: pick modulo size, one bit a cycle
				ST_MOD: begin
					rem_q <= rem_try[SW-1:0];
					bit_q <= bit_q + PCW'(1);
					if (bit_q == PCW'(gmt_pkg::PICK_W - 1)) begin
						idx_q   <= rem_try[SW-1:0];
						n_q     <= '0;
						state_q <= ST_TG_RD;
					end
				end
				// tick: forward scan for a gossip target
				ST_TG_RD: begin
					if (n_q >= size_q) begin
						res_valid_q <= 1'b1;
						res_q <= gmt_pkg::quiet_result(
							gmt_pkg::COUNT_W'(size_q), 1'b1, 1'b1);
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_TG_EX;
					end
				end
				ST_TG_EX: begin
					if (rd.addr != own_q && !rd.failed) begin
						target_q <= rd.addr;
						i_q      <= '0;
						state_q  <= ST_TX_RD;
					end else begin
						n_q     <= n_q + ONE_C;
						idx_q   <= (idx_q + ONE_C == size_q) ? '0 : idx_q + ONE_C;
						state_q <= ST_TG_RD;
					end
				end
				// send the whole table
				ST_TX_RD: begin
					state_q <= ST_TX_EX;
				end
				ST_TX_EX: begin
					res_valid_q          <= 1'b1;
					res_q.is_send        <= 1'b1;
					res_q.target_address <= target_q;
					res_q.entry_address  <= rd.addr;
					res_q.entry_beats    <= rd.beats;
					res_q.entry_failed   <= rd.failed;
					res_q.entry_stamp    <= rd.stamp;
					res_q.last           <= (i_q + ONE_C == size_q);
					res_q.member_count   <= gmt_pkg::COUNT_W'(size_q);
					res_q.joined         <= joined_q;
					res_q.accepted       <= 1'b1;
					if (i_q + ONE_C == size_q) begin
						state_q <= ST_IDLE;
					end else begin
						i_q     <= i_q + ONE_C;
						state_q <= ST_TX_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= DEPTH_C)
		else $error("table size beyond depth");

	a_send_joined: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_send |-> result.joined && result.accepted)
		else $error("table sent while not joined");

	a_tx_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TX_EX |-> i_q < size_q)
		else $error("send index past table end");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("last result while still busy");

endmodule
`default_nettype wire
